// File: rtl/ibc_pkg.sv
// Shared types, register codes and reset constants of the IMU bias calibration core.
`timescale 1ns / 1ps

package ibc_pkg;

  localparam int unsigned BiasW   = 16;
  localparam int unsigned StepW   = 7;
  localparam int unsigned CountW  = 8;
  localparam int unsigned NumAxes = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  typedef logic signed [BiasW-1:0] bias_t;
  typedef logic [StepW-1:0]        step_t;
  typedef logic [CountW-1:0]       count_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgAccelStartX  = 3'd0,
    CfgAccelStartY  = 3'd1,
    CfgAccelStartZ  = 3'd2,
    CfgCoarseStep   = 3'd3,
    CfgFineStep     = 3'd4,
    CfgFineAfter    = 3'd5,
    CfgTotalSamples = 3'd6,
    CfgGravityTgt   = 3'd7
  } cfg_idx_e;

  localparam step_t  CoarseStepRst   = 7'd10;
  localparam step_t  FineStepRst     = 7'd2;
  localparam count_t FineAfterRst    = 8'd100;
  localparam count_t TotalSamplesRst = 8'd200;
  localparam bias_t  GravityTgtRst   = 16'sd16384;

  // Gyro lanes always step by one count.
  localparam step_t  GyroStep        = 7'd1;

  typedef struct packed {
    bias_t  accel_start_x;
    bias_t  accel_start_y;
    bias_t  accel_start_z;
    step_t  coarse_step;
    step_t  fine_step;
    count_t fine_after;
    count_t total_samples;
    bias_t  gravity_target;
  } cfg_t;

  typedef struct packed {
    bias_t [NumAxes-1:0] acc_offs;
    bias_t [NumAxes-1:0] gyr_offs;
    count_t              samples_seen;
    logic                done_res;
  } result_t;

  typedef struct packed {
    count_t count;
    logic   active;
  } stat_t;

endpackage

// File: rtl/ibc_lane.sv
// One axis lane: moves a bias one saturating step against the sign of its residual, or holds it inside the deadband.
`timescale 1ns / 1ps

module ibc_lane
  import ibc_pkg::*;
(
  input  bias_t bias_i,
  input  bias_t reading_i,
  input  bias_t target_i,
  input  logic  deadband_i,
  input  step_t step_i,
  output bias_t bias_o
);

  logic signed [BiasW:0]   resid;
  logic signed [BiasW:0]   thr;
  logic signed [BiasW+1:0] sum;
  logic signed [BiasW+1:0] step_ext;
  logic                    above;
  logic                    below;

  localparam logic signed [BiasW+1:0] SatMax = (BiasW+2)'(2 ** (BiasW - 1) - 1);
  localparam logic signed [BiasW+1:0] SatMin = -(BiasW+2)'(2 ** (BiasW - 1));

  always_comb begin
    resid    = (BiasW+1)'(reading_i) - (BiasW+1)'(target_i);
    thr      = deadband_i ? (BiasW+1)'(1) : '0;
    above    = resid > thr;
    below    = resid < -thr;
    step_ext = $signed({{(BiasW+2-StepW){1'b0}}, step_i});
    if (above) begin
      sum = (BiasW+2)'(bias_i) - step_ext;
    end else if (below) begin
      sum = (BiasW+2)'(bias_i) + step_ext;
    end else begin
      sum = (BiasW+2)'(bias_i);
    end
    if (sum > SatMax) begin
      bias_o = bias_t'(SatMax[BiasW-1:0]);
    end else if (sum < SatMin) begin
      bias_o = bias_t'(SatMin[BiasW-1:0]);
    end else begin
      bias_o = sum[BiasW-1:0];
    end
  end

endmodule

// File: rtl/ibc_merge.sv
// Bias and sample-count state: merges the lane results into the next state and the result item.
`timescale 1ns / 1ps

module ibc_merge
  import ibc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_acc_i,
  input  logic                start_i,
  input  cfg_t                cfg_i,
  input  bias_t [NumAxes-1:0] accel_new_i,
  input  bias_t [NumAxes-1:0] gyro_new_i,
  output bias_t [NumAxes-1:0] acc_offs_o,
  output bias_t [NumAxes-1:0] gyr_offs_o,
  output step_t               step_o,
  output stat_t               stat_o,
  output result_t             res_o
);

  bias_t [NumAxes-1:0] accel_q, accel_d;
  bias_t [NumAxes-1:0] gyro_q, gyro_d;
  count_t              count_q, count_d;
  logic                active;

  assign active = count_q < cfg_i.total_samples;
  assign step_o = (count_q >= cfg_i.fine_after) ? cfg_i.fine_step : cfg_i.coarse_step;

  always_comb begin
    accel_d = accel_q;
    gyro_d  = gyro_q;
    count_d = count_q;
    if (item_acc_i) begin
      if (start_i) begin
        accel_d = {cfg_i.accel_start_z, cfg_i.accel_start_y, cfg_i.accel_start_x};
        gyro_d  = '0;
        count_d = '0;
      end else if (active) begin
        accel_d = accel_new_i;
        gyro_d  = gyro_new_i;
        count_d = count_q + count_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= '0;
      gyro_q  <= '0;
      count_q <= '0;
    end else begin
      accel_q <= accel_d;
      gyro_q  <= gyro_d;
      count_q <= count_d;
    end
  end

  assign acc_offs_o = accel_q;
  assign gyr_offs_o = gyro_q;
  assign stat_o     = '{count: count_q, active: active};

  always_comb begin
    res_o.acc_offs     = accel_d;
    res_o.gyr_offs     = gyro_d;
    res_o.samples_seen = count_d;
    res_o.done_res     = count_d >= cfg_i.total_samples;
  end

endmodule

// File: rtl/imu_bias_calibration_core.sv
// Top level of the IMU bias calibration core: configuration, six axis lanes, state and output.
`timescale 1ns / 1ps
// The result item of an accepted input item is registered and valid in the cycle after acceptance.
// Throughput: one item per cycle except while a stall blocks the input, as described below.
// The output register frees itself in the cycle it is taken, so a stall only blocks the input
// while a finished result is still waiting on the master side.
// Reset (asynchronous, active low): biases and sample count clear to zero, the configuration
// registers take their default values and the output register is empty.

module imu_bias_calibration_core
  import ibc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // Input item stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // tdata, lowest bit up: accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z.
  input  logic [95:0]        s_axis_tdata,
  // tuser: action (0 = sample, 1 = start a new run).
  input  logic               s_axis_tuser,
  // Result item stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // tdata, lowest bit up: bias_accel_x, bias_accel_y, bias_accel_z, bias_gyro_x,
  // bias_gyro_y, bias_gyro_z, samples_seen, done_res, then seven zero bits.
  output logic [111:0]       m_axis_tdata
);

  // Configuration registers. Write them only while the core is idle; the core itself does not enforce this.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_start_x  <= '0;
      cfg_q.accel_start_y  <= '0;
      cfg_q.accel_start_z  <= '0;
      cfg_q.coarse_step    <= CoarseStepRst;
      cfg_q.fine_step      <= FineStepRst;
      cfg_q.fine_after     <= FineAfterRst;
      cfg_q.total_samples  <= TotalSamplesRst;
      cfg_q.gravity_target <= GravityTgtRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgAccelStartX:  cfg_q.accel_start_x  <= cfg_wdata_i;
        CfgAccelStartY:  cfg_q.accel_start_y  <= cfg_wdata_i;
        CfgAccelStartZ:  cfg_q.accel_start_z  <= cfg_wdata_i;
        CfgCoarseStep:   cfg_q.coarse_step    <= cfg_wdata_i[StepW-1:0];
        CfgFineStep:     cfg_q.fine_step      <= cfg_wdata_i[StepW-1:0];
        CfgFineAfter:    cfg_q.fine_after     <= cfg_wdata_i[CountW-1:0];
        CfgTotalSamples: cfg_q.total_samples  <= cfg_wdata_i[CountW-1:0];
        CfgGravityTgt:   cfg_q.gravity_target <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake. A new item enters whenever the output register is empty or being emptied.
  logic    out_valid_q;
  result_t res_q;
  logic    item_acc;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign item_acc      = s_axis_tvalid && s_axis_tready;

  // Lanes: three accelerometer lanes share the phase step, three gyro lanes use a
  // fixed unit step with a deadband of one count around zero.
  bias_t [NumAxes-1:0] acc_offs, gyr_offs;
  bias_t [NumAxes-1:0] accel_new, gyro_new;
  step_t               acc_step;
  stat_t               stat;
  result_t             res_next;

  for (genvar i = 0; i < NumAxes; i++) begin : g_lane
    bias_t accel_tgt;
    assign accel_tgt = (i == NumAxes - 1) ? cfg_q.gravity_target : '0;

    ibc_lane u_accel_lane (
      .bias_i     (acc_offs[i]),
      .reading_i  (s_axis_tdata[BiasW*i +: BiasW]),
      .target_i   (accel_tgt),
      .deadband_i (1'b0),
      .step_i     (acc_step),
      .bias_o     (accel_new[i])
    );

    ibc_lane u_gyro_lane (
      .bias_i     (gyr_offs[i]),
      .reading_i  (s_axis_tdata[BiasW*(NumAxes+i) +: BiasW]),
      .target_i   ('0),
      .deadband_i (1'b1),
      .step_i     (GyroStep),
      .bias_o     (gyro_new[i])
    );
  end

  // State and merge: a start item reloads the run, a sample of an active run takes the
  // lane results, and any other sample leaves the state as it is.
  ibc_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_acc_i   (item_acc),
    .start_i      (s_axis_tuser),
    .cfg_i        (cfg_q),
    .accel_new_i  (accel_new),
    .gyro_new_i   (gyro_new),
    .acc_offs_o   (acc_offs),
    .gyr_offs_o   (gyr_offs),
    .step_o       (acc_step),
    .stat_o       (stat),
    .res_o        (res_next)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      res_q <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, res_q.done_res, res_q.samples_seen,
                          res_q.gyr_offs[2], res_q.gyr_offs[1], res_q.gyr_offs[0],
                          res_q.acc_offs[2], res_q.acc_offs[1], res_q.acc_offs[0]};

`ifndef SYNTH
  // Every accepted item leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_acc |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  // A start item always reports an empty run.
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_acc && s_axis_tuser |=> res_q.samples_seen == '0 && stat.count == '0)
    else $error("start item did not clear the sample count");

  // A sample of an active run advances the count by exactly one.
  a_sample_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_acc && !s_axis_tuser && stat.active
      |=> stat.count == count_t'($past(stat.count) + count_t'(1)))
    else $error("active sample did not advance the count");

  // A sample after the run is done leaves the count alone.
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_acc && !s_axis_tuser && !stat.active |=> $stable(stat.count))
    else $error("sample after done changed the count");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking testbench of the IMU bias calibration core: directed table, then random runs.
`timescale 1ns / 1ps

module testbench;
  import ibc_pkg::*;

  localparam int    CycleLimit   = 1000000;
  localparam int    ItemTarget   = 1450;
  localparam int    QuietFrom    = 1250;
  localparam bias_t BiasHi       = 16'sh7FFF;
  localparam bias_t BiasLo       = 16'sh8000;

  // One result item as the core reports it.
  typedef struct packed {
    bias_t  acc_x;
    bias_t  acc_y;
    bias_t  acc_z;
    bias_t  gyr_x;
    bias_t  gyr_y;
    bias_t  gyr_z;
    count_t seen;
    logic   done;
  } bias_report_t;

  typedef enum logic {RowItem, RowConfig} row_kind_e;

  // One row of the directed table: a register write or an input item, the latter
  // optionally with a result typed in by hand.
  typedef struct packed {
    row_kind_e       kind;
    cfg_idx_e        reg_idx;
    logic [CfgW-1:0] reg_val;
    logic            action;
    logic [95:0]     readings;
    logic            typed;
    bias_report_t    want;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [CfgW-1:0]    cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [95:0]        s_axis_tdata  = '0;
  logic               s_axis_tuser  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [111:0]       m_axis_tdata;

  imu_bias_calibration_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predictor copy of the configuration and of the calibration state.
  bias_t  start_bias [3];
  step_t  coarse_step_q;
  step_t  fine_step_q;
  count_t fine_after_q;
  count_t total_q;
  bias_t  gravity_q;
  bias_t  acc_offs [3];
  bias_t  gyr_offs [3];
  count_t samples_q;

  bias_report_t bias_reports_due [$];
  int           items_sent = 0;
  int           errors     = 0;
  int           reports    = 0;
  int           cycles     = 0;
  int           stall_left = 0;
  bit           quiet      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // One sign step toward the target, with a deadband and int16 saturation.
  function automatic bias_t nudge(bias_t b, bias_t reading, bias_t target, int dead, int step);
    int r;
    int v;
    r = int'(reading) - int'(target);
    v = int'(b);
    if (r > dead) begin
      v = v - step;
    end else if (r < -dead) begin
      v = v + step;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return bias_t'(v);
  endfunction

  // Applies one input item to the predicted state and returns the report it yields.
  function automatic bias_report_t advance_calibration(logic act, logic [95:0] rd);
    bias_t        r [6];
    int           step;
    bias_report_t rep;
    for (int i = 0; i < 6; i++) r[i] = rd[16*i +: 16];
    if (act) begin
      for (int i = 0; i < 3; i++) begin
        acc_offs[i] = start_bias[i];
        gyr_offs[i] = '0;
      end
      samples_q = '0;
    end else if (samples_q < total_q) begin
      step = (samples_q >= fine_after_q) ? int'(fine_step_q) : int'(coarse_step_q);
      acc_offs[0] = nudge(acc_offs[0], r[0], 16'sd0, 0, step);
      acc_offs[1] = nudge(acc_offs[1], r[1], 16'sd0, 0, step);
      acc_offs[2] = nudge(acc_offs[2], r[2], gravity_q, 0, step);
      for (int i = 0; i < 3; i++) gyr_offs[i] = nudge(gyr_offs[i], r[3+i], 16'sd0, 1, 1);
      samples_q = samples_q + 8'd1;
    end
    rep.acc_x = acc_offs[0];
    rep.acc_y = acc_offs[1];
    rep.acc_z = acc_offs[2];
    rep.gyr_x = gyr_offs[0];
    rep.gyr_y = gyr_offs[1];
    rep.gyr_z = gyr_offs[2];
    rep.seen  = samples_q;
    rep.done  = (samples_q >= total_q);
    return rep;
  endfunction

  function automatic void set_register(cfg_idx_e idx, logic [CfgW-1:0] v);
    case (idx)
      CfgAccelStartX:  start_bias[0] = v;
      CfgAccelStartY:  start_bias[1] = v;
      CfgAccelStartZ:  start_bias[2] = v;
      CfgCoarseStep:   coarse_step_q = v[StepW-1:0];
      CfgFineStep:     fine_step_q   = v[StepW-1:0];
      CfgFineAfter:    fine_after_q  = v[CountW-1:0];
      CfgTotalSamples: total_q       = v[CountW-1:0];
      default:         gravity_q     = v;
    endcase
  endfunction

  function automatic stim_row_t cfg_row(cfg_idx_e idx, logic [CfgW-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind    = RowConfig;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t item_row(logic act, bias_t ax, bias_t ay, bias_t az,
                                         bias_t gx, bias_t gy, bias_t gz);
    stim_row_t r;
    r = '0;
    r.kind     = RowItem;
    r.action   = act;
    r.readings = {gz, gy, gx, az, ay, ax};
    return r;
  endfunction

  function automatic stim_row_t typed_row(stim_row_t r, bias_report_t w);
    r.typed = 1'b1;
    r.want  = w;
    return r;
  endfunction

  // Readings cluster around the target now and then so that the deadband and both
  // step directions are hit, and sit at the int16 limits now and then.
  function automatic bias_t pick_reading(bias_t center);
    logic [31:0] raw;
    int          v;
    raw = $urandom();
    case (raw[2:0])
      3'd0, 3'd1: v = int'(center) + int'(raw[10:8]) - 4;
      3'd2:       v = raw[3] ? 32767 : -32768;
      default:    v = int'(bias_t'(raw[31:16]));
    endcase
    return bias_t'(v);
  endfunction

  function automatic logic [CfgW-1:0] random_value(cfg_idx_e idx);
    logic [31:0] raw;
    raw = $urandom();
    case (idx)
      CfgCoarseStep, CfgFineStep: begin
        if (raw[20:16] == 5'd0) return '0;
        if (raw[20:16] == 5'd1) return 16'd127;
        return {9'd0, raw[6:0]};
      end
      CfgFineAfter: begin
        if (raw[19:18] == 2'd0) return '0;
        if (raw[19:18] == 2'd1) return {8'd0, raw[7:0]};
        return {11'd0, raw[4:0]};
      end
      CfgTotalSamples: begin
        // Mostly short runs; a long run and an empty run now and then.
        if (raw[19:16] == 4'd0) return '0;
        if (raw[19:16] == 4'd1) return 16'd255;
        if (raw[19:16] == 4'd2) return {8'd0, raw[7:0]};
        return {10'd0, raw[5:0]};
      end
      default: begin
        if (raw[19:18] == 2'd0) return BiasHi;
        if (raw[19:18] == 2'd1) return BiasLo;
        return raw[15:0];
      end
    endcase
  endfunction

  // Register writes only happen once the core has returned every pending result.
  task automatic write_register(cfg_idx_e idx, logic [CfgW-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (bias_reports_due.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    set_register(idx, val);
  endtask

  // Offers one item from a falling edge and returns on the falling edge after acceptance.
  task automatic send_item(logic act, logic [95:0] rd, logic typed, bias_report_t want);
    int           gap;
    bias_report_t predicted;
    if (items_sent >= QuietFrom) quiet = 1'b1;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= rd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = advance_calibration(act, rd);
    bias_reports_due.push_back(typed ? want : predicted);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random(logic act);
    logic [95:0] rd;
    rd = {pick_reading(16'sd0), pick_reading(16'sd0), pick_reading(16'sd0),
          pick_reading(gravity_q), pick_reading(16'sd0), pick_reading(16'sd0)};
    send_item(act, rd, 1'b0, '0);
  endtask

  // Result side: random stall bursts, none in the closing part of the run.
  always @(negedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 14);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    bias_report_t got;
    bias_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.acc_x = m_axis_tdata[15:0];
      got.acc_y = m_axis_tdata[31:16];
      got.acc_z = m_axis_tdata[47:32];
      got.gyr_x = m_axis_tdata[63:48];
      got.gyr_y = m_axis_tdata[79:64];
      got.gyr_z = m_axis_tdata[95:80];
      got.seen  = m_axis_tdata[103:96];
      got.done  = m_axis_tdata[104];
      if (bias_reports_due.size() == 0) begin
        errors++;
        if (reports < 10) begin
          $display("unexpected result item: %0d %0d %0d %0d %0d %0d seen %0d done %0d",
                   got.acc_x, got.acc_y, got.acc_z, got.gyr_x, got.gyr_y, got.gyr_z,
                   got.seen, got.done);
        end
        reports++;
      end else begin
        want = bias_reports_due.pop_front();
        if (got.acc_x !== want.acc_x || got.acc_y !== want.acc_y ||
            got.acc_z !== want.acc_z || got.gyr_x !== want.gyr_x ||
            got.gyr_y !== want.gyr_y || got.gyr_z !== want.gyr_z ||
            got.seen !== want.seen || got.done !== want.done) begin
          errors++;
          if (reports < 10) begin
            $display("mismatch: expected %0d %0d %0d %0d %0d %0d seen %0d done %0d",
                     want.acc_x, want.acc_y, want.acc_z, want.gyr_x, want.gyr_y,
                     want.gyr_z, want.seen, want.done);
            $display("          actual   %0d %0d %0d %0d %0d %0d seen %0d done %0d",
                     got.acc_x, got.acc_y, got.acc_z, got.gyr_x, got.gyr_y,
                     got.gyr_z, got.seen, got.done);
          end
          reports++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    stim_row_t stim_rows [$];
    stim_row_t row;
    int        run_len;
    bit        first_phase;

    // Predictor state after reset.
    for (int i = 0; i < 3; i++) begin
      start_bias[i] = '0;
      acc_offs[i]   = '0;
      gyr_offs[i]   = '0;
    end
    coarse_step_q = CoarseStepRst;
    fine_step_q   = FineStepRst;
    fine_after_q  = FineAfterRst;
    total_q       = TotalSamplesRst;
    gravity_q     = GravityTgtRst;
    samples_q     = '0;

    // A sample before any start works on the reset state: x and y step against
    // their readings, z sits on gravity, two gyro lanes leave the deadband.
    stim_rows.push_back(typed_row(
      item_row(1'b0, BiasHi, BiasLo, 16'sd16384, 16'sd1, 16'sd2, -16'sd2),
      bias_report_t'{-16'sd10, 16'sd10, 16'sd0, 16'sd0, -16'sd1, 16'sd1, 8'd1, 1'b0}));
    stim_rows.push_back(item_row(1'b0, 16'sd0, 16'sd0, 16'sd16384, -16'sd1, 16'sd1, 16'sd0));
    stim_rows.push_back(typed_row(
      item_row(1'b1, 16'sh5A5A, 16'shA5A5, 16'sh0F0F, 16'shF0F0, 16'sh3C3C, 16'shC3C3),
      bias_report_t'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b0}));
    // Extreme start biases, the largest fine step from the very first sample.
    stim_rows.push_back(cfg_row(CfgAccelStartX, BiasHi));
    stim_rows.push_back(cfg_row(CfgAccelStartY, BiasLo));
    stim_rows.push_back(cfg_row(CfgAccelStartZ, BiasLo));
    stim_rows.push_back(cfg_row(CfgCoarseStep, 16'd1));
    stim_rows.push_back(cfg_row(CfgFineStep, 16'd127));
    stim_rows.push_back(cfg_row(CfgFineAfter, 16'd0));
    stim_rows.push_back(cfg_row(CfgTotalSamples, 16'd2));
    stim_rows.push_back(cfg_row(CfgGravityTgt, BiasHi));
    stim_rows.push_back(typed_row(
      item_row(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
      bias_report_t'{BiasHi, BiasLo, BiasLo, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b0}));
    // x and y saturate at the int16 limits, z climbs away from the bottom.
    stim_rows.push_back(typed_row(
      item_row(1'b0, -16'sd5, 16'sd5, BiasLo, BiasHi, BiasLo, 16'sd0),
      bias_report_t'{BiasHi, BiasLo, -16'sd32641, -16'sd1, 16'sd1, 16'sd0, 8'd1, 1'b0}));
    stim_rows.push_back(item_row(1'b0, 16'sd1, -16'sd1, BiasHi, 16'sd2, -16'sd2, 16'sd1));
    // The run is done: this sample must leave everything as it was.
    stim_rows.push_back(item_row(1'b0, BiasHi, BiasHi, BiasHi, BiasHi, BiasHi, BiasHi));
    // An empty run is done at once.
    stim_rows.push_back(cfg_row(CfgTotalSamples, 16'd0));
    stim_rows.push_back(typed_row(
      item_row(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0),
      bias_report_t'{BiasHi, BiasLo, BiasLo, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b1}));
    stim_rows.push_back(item_row(1'b0, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7));
    // Zero steps freeze the accel biases while the gyro lanes still move.
    stim_rows.push_back(cfg_row(CfgTotalSamples, 16'd255));
    stim_rows.push_back(cfg_row(CfgCoarseStep, 16'd0));
    stim_rows.push_back(cfg_row(CfgFineStep, 16'd0));
    stim_rows.push_back(cfg_row(CfgFineAfter, 16'd255));
    stim_rows.push_back(item_row(1'b1, BiasLo, BiasLo, BiasLo, BiasLo, BiasLo, BiasLo));
    stim_rows.push_back(item_row(1'b0, 16'sd100, -16'sd100, 16'sd0, 16'sd50, -16'sd50, 16'sd1));
    // Default-like settings with a coarse-to-fine switch after the first sample,
    // and a gravity change in the middle of the run.
    stim_rows.push_back(cfg_row(CfgCoarseStep, 16'd10));
    stim_rows.push_back(cfg_row(CfgFineStep, 16'd2));
    stim_rows.push_back(cfg_row(CfgFineAfter, 16'd1));
    stim_rows.push_back(cfg_row(CfgTotalSamples, 16'd4));
    stim_rows.push_back(cfg_row(CfgAccelStartX, 16'd0));
    stim_rows.push_back(cfg_row(CfgAccelStartY, 16'd0));
    stim_rows.push_back(cfg_row(CfgAccelStartZ, 16'd0));
    stim_rows.push_back(cfg_row(CfgGravityTgt, 16'd16384));
    stim_rows.push_back(item_row(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    stim_rows.push_back(item_row(1'b0, BiasLo, BiasHi, 16'sd16385, 16'sd1, -16'sd1, 16'sd0));
    stim_rows.push_back(item_row(1'b0, 16'sd3, -16'sd3, 16'sd16383, BiasHi, BiasLo, 16'sd2));
    stim_rows.push_back(cfg_row(CfgGravityTgt, 16'd0));
    stim_rows.push_back(item_row(1'b0, 16'sd0, 16'sd1, 16'sd1, -16'sd2, 16'sd2, -16'sd1));
    stim_rows.push_back(item_row(1'b0, -16'sd1, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0));
    stim_rows.push_back(item_row(1'b0, 16'sd9, 16'sd9, 16'sd9, 16'sd9, 16'sd9, 16'sd9));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == RowConfig) begin
        write_register(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.action, row.readings, row.typed, row.want);
      end
    end

    // Random runs: mostly a start followed by a full run of samples, with a stray
    // start now and then, a run left without a start, and occasional mid-run writes.
    first_phase = 1'b1;
    while (items_sent < ItemTarget) begin
      if (items_sent >= QuietFrom) quiet = 1'b1;
      for (int i = 0; i < 8; i++) begin
        if (first_phase || $urandom_range(0, 1) == 0) begin
          write_register(cfg_idx_e'(i[CfgIdxW-1:0]), random_value(cfg_idx_e'(i[CfgIdxW-1:0])));
        end
      end
      first_phase = 1'b0;
      if ($urandom_range(0, 7) != 0) send_random(1'b1);
      run_len = int'(total_q) + int'($urandom_range(0, 3));
      for (int k = 0; k < run_len && items_sent < ItemTarget; k++) begin
        send_random(($urandom_range(0, 39) == 0) ? 1'b1 : 1'b0);
        if (k == run_len / 2 && $urandom_range(0, 5) == 0) begin
          row.reg_idx = cfg_idx_e'($urandom_range(0, 7));
          write_register(row.reg_idx, random_value(row.reg_idx));
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (bias_reports_due.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ibc_pkg.sv
rtl/ibc_lane.sv
rtl/ibc_merge.sv
rtl/imu_bias_calibration_core.sv
tb/testbench.sv
